// ----- rtl/core/brms_pkg.sv -----
// Package for the block RMS meter: sizing constants, beat payload types and the
// controller-to-datapath command and status structs. No dependencies.
package brms_pkg;

    localparam int MAX_BLOCK   = 4096;
    localparam int SAMPLE_BITS = 16;

    localparam int RMS_W   = 16;
    localparam int USED_W  = 13;

    localparam int SQ_W    = 2 * SAMPLE_BITS - 1;
    localparam int MEAN_W  = 2 * SAMPLE_BITS - 1;
    localparam int CNT_W   = $clog2(MAX_BLOCK + 1);
    localparam int SUM_W   = SQ_W + $clog2(MAX_BLOCK + 1);
    localparam int ROOT_W  = SAMPLE_BITS;
    localparam int RAD_W   = 2 * ROOT_W;
    localparam int STEP_W  = $clog2(SUM_W + ROOT_W + 1);

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          block_last;
    } in_beat_t;

    typedef struct packed {
        logic [RMS_W-1:0]  rms_level;
        logic [USED_W-1:0] samples_used;
        logic              overflowed;
    } out_beat_t;

    typedef struct packed {
        logic acc_en;
        logic div_start;
        logic div_step;
        logic sqrt_start;
        logic sqrt_step;
        logic out_load;
    } brms_cmd_t;

    typedef struct packed {
        logic out_busy;
    } brms_sts_t;

endpackage

// ----- rtl/core/brms_datapath.sv -----
// Datapath of the block RMS meter: square and accumulate, restoring divider,
// digit-by-digit square root and the result register. Depends on brms_pkg.
module brms_datapath
    import brms_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  brms_cmd_t cmd,
    output brms_sts_t sts,
    input  in_beat_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    logic [SAMPLE_BITS-1:0] mag;
    logic                   keep;

    logic [SQ_W-1:0]   sq_reg;
    logic              sq_vld_reg;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [CNT_W-1:0]  tally_reg;
    logic              ovf_reg;

    logic [SUM_W-1:0]  quo_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  divisor_reg;
    logic              ovf_hold_reg;
    logic [CNT_W:0]    dtrial;
    logic              dge;

    logic [MEAN_W-1:0] mean;
    logic [RAD_W-1:0]  rad_reg;
    logic [ROOT_W+1:0] srem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [ROOT_W+1:0] sshift;
    logic [ROOT_W+1:0] strial;
    logic              sge;

    logic              m_valid_reg;
    out_beat_t         m_data_reg;

    assign mag  = s_data.sample[SAMPLE_BITS-1] ? (~s_data.sample + 1'b1) : s_data.sample;
    assign keep = (tally_reg < CNT_W'(MAX_BLOCK));
    assign sum_next = sum_reg + (sq_vld_reg ? SUM_W'(sq_reg) : '0);

    always_ff @(posedge aclk) begin
        sq_reg <= SQ_W'(mag) * SQ_W'(mag);
        if (!aresetn) begin
            sq_vld_reg <= 1'b0;
            sum_reg    <= '0;
            tally_reg  <= '0;
            ovf_reg    <= 1'b0;
        end else begin
            sq_vld_reg <= cmd.acc_en && keep;
            if (cmd.div_start) begin
                sum_reg   <= '0;
                tally_reg <= '0;
                ovf_reg   <= 1'b0;
            end else begin
                sum_reg <= sum_next;
                if (cmd.acc_en) begin
                    if (keep) begin
                        tally_reg <= tally_reg + 1'b1;
                    end else begin
                        ovf_reg <= 1'b1;
                    end
                end
            end
        end
    end

    assign dtrial = {rem_reg, quo_reg[SUM_W-1]};
    assign dge    = (dtrial >= {1'b0, divisor_reg});

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            quo_reg      <= sum_next;
            rem_reg      <= '0;
            divisor_reg  <= tally_reg;
            ovf_hold_reg <= ovf_reg;
        end else if (cmd.div_step) begin
            quo_reg <= {quo_reg[SUM_W-2:0], dge};
            rem_reg <= dge ? CNT_W'(dtrial - {1'b0, divisor_reg}) : CNT_W'(dtrial);
        end
    end

    assign mean   = (divisor_reg != '0) ? quo_reg[MEAN_W-1:0] : '0;
    assign sshift = {srem_reg[ROOT_W-1:0], rad_reg[RAD_W-1:RAD_W-2]};
    assign strial = {root_reg, 2'b01};
    assign sge    = (sshift >= strial);

    always_ff @(posedge aclk) begin
        if (cmd.sqrt_start) begin
            rad_reg  <= RAD_W'(mean);
            srem_reg <= '0;
            root_reg <= '0;
        end else if (cmd.sqrt_step) begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            srem_reg <= sge ? (sshift - strial) : sshift;
            root_reg <= {root_reg[ROOT_W-2:0], sge};
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_data_reg.rms_level    <= RMS_W'(root_reg);
            m_data_reg.samples_used <= USED_W'(divisor_reg);
            m_data_reg.overflowed   <= ovf_hold_reg;
        end
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign sts.out_busy = m_valid_reg && !m_ready;
    assign m_valid      = m_valid_reg;
    assign m_data       = m_data_reg;

endmodule

// ----- rtl/core/brms_ctrl.sv -----
// Controller of the block RMS meter: sequences accumulate, divide, root and
// result hand-off, and counts the iterations. Depends on brms_pkg.
module brms_ctrl
    import brms_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_last,
    output logic      s_ready,
    input  brms_sts_t sts,
    output brms_cmd_t cmd
);

    typedef enum logic [4:0] {
        ST_ACC  = 5'b00001,
        ST_ADD  = 5'b00010,
        ST_DIV  = 5'b00100,
        ST_SQRT = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_ACC: begin
                s_ready    = 1'b1;
                cmd.acc_en = s_valid;
                if (s_valid && s_last) begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                cmd.div_start = 1'b1;
                step_next     = '0;
                state_next    = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (step_reg == STEP_W'(SUM_W - 1)) begin
                    step_next  = '0;
                    state_next = ST_SQRT;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_SQRT: begin
                if (step_reg == '0) begin
                    cmd.sqrt_start = 1'b1;
                end else begin
                    cmd.sqrt_step = 1'b1;
                end
                if (step_reg == STEP_W'(ROOT_W)) begin
                    step_next  = '0;
                    state_next = ST_OUT;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_OUT: begin
                if (!sts.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_ACC;
                end
            end
            default: begin
                state_next = ST_ACC;
                step_next  = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_ACC;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

// ----- rtl/core/block_rms_meter.sv -----
// Top level of the block RMS meter: joins the controller and the datapath.
// Depends on brms_pkg, brms_ctrl and brms_datapath.
//
//   Channel  Direction  Handshake          Beat payload
//   s_       in         s_valid/s_ready    in_beat_t  (sample, block_last)
//   m_       out        m_valid/m_ready    out_beat_t (rms_level, samples_used, overflowed)
//
// Samples are taken one per cycle while a block is accumulating.
// After the last beat of a block the input is held off while the sum is finished,
// the bit-serial divider and the digit-by-digit square root run, and the result
// register is loaded; the load waits while that register is still full.
// Reset clears the sum, the count, the overflow flag and the result valid.
module block_rms_meter
    import brms_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_beat_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    brms_cmd_t cmd;
    brms_sts_t sts;

    brms_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_last  (s_data.block_last),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    brms_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .sts     (sts),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ----- rtl/core/brms_checker.sv -----
// Port-level checker for the block RMS meter and its bind to the top level.
// Depends on brms_pkg.
module brms_checker
    import brms_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_beat_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input out_beat_t m_data
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("Result beat changed while stalled.");

    a_used_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.samples_used != '0) &&
                    (m_data.samples_used <= USED_W'(MAX_BLOCK)))
        else $error("Result sample count out of range.");

    a_rms_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.rms_level <= RMS_W'(1 << (SAMPLE_BITS - 1)))
        else $error("Result level above full scale.");

    a_ovf_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.overflowed |-> m_data.samples_used == USED_W'(MAX_BLOCK))
        else $error("Overflow flagged on a block that was not full.");

    a_last_stalls: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.block_last |=> !s_ready)
        else $error("Input still ready right after the last beat of a block.");

endmodule

bind block_rms_meter brms_checker u_brms_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
